[rtl/wrcfs_pkg.sv]
// ----------------------------------------------------------------------------
// wrcfs_pkg
// Shared types and constants of the class-filtered weighted random selector.
// ----------------------------------------------------------------------------
package wrcfs_pkg;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam int CLASS_W = 3;
   localparam int DRAW_W  = 16;
   localparam int INDEX_W = 3;
   localparam int MASK_W  = 8;

   localparam logic [16:0] DRAW_MAX = 17'd65535;

   localparam logic [63:0] RESET_ENTRY_WEIGHTS = 64'h0;
   localparam logic [63:0] RESET_CLASS_MASKS   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      REG_ENTRY_WEIGHTS,
      REG_CLASS_MASKS,
      REG_PRESENT_MASK,
      REG_SPAWNABLE_MASK,
      REG_REQUIRE_VALID_CLASS
   } reg_index_type;

   typedef enum logic [1:0] {
      PICK_WEIGHTED,
      PICK_ZERO_WEIGHT,
      PICK_FALLBACK,
      PICK_NONE
   } pick_kind_type;

   typedef struct packed {
      logic [63:0]       entry_weights;
      logic [63:0]       class_masks;
      logic [MASK_W-1:0] present_mask;
      logic [MASK_W-1:0] spawnable_mask;
      logic              require_valid_class;
   } cfg_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] entry_index;
      pick_kind_type      pick_kind;
      logic [MASK_W-1:0]  eligible_mask;
   } result_type;

endpackage

[rtl/wrcfs_csr.sv]
// ----------------------------------------------------------------------------
// wrcfs_csr
// Configuration register file with an APB-style write and read port.
// ----------------------------------------------------------------------------
module wrcfs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [wrcfs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [wrcfs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [wrcfs_pkg::CSR_DATA_W-1:0] prdata,
   output wrcfs_pkg::cfg_type               cfg
);
   import wrcfs_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_en;

   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1:3]);
   assign write_en  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_ENTRY_WEIGHTS:       cfg_in.entry_weights       = pwdata;
            REG_CLASS_MASKS:         cfg_in.class_masks         = pwdata;
            REG_PRESENT_MASK:        cfg_in.present_mask        = pwdata[MASK_W-1:0];
            REG_SPAWNABLE_MASK:      cfg_in.spawnable_mask      = pwdata[MASK_W-1:0];
            REG_REQUIRE_VALID_CLASS: cfg_in.require_valid_class = pwdata[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_weights       <= RESET_ENTRY_WEIGHTS;
         cfg_ff.class_masks         <= RESET_CLASS_MASKS;
         cfg_ff.present_mask        <= '0;
         cfg_ff.spawnable_mask      <= '0;
         cfg_ff.require_valid_class <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_ENTRY_WEIGHTS:       prdata = cfg_ff.entry_weights;
         REG_CLASS_MASKS:         prdata = cfg_ff.class_masks;
         REG_PRESENT_MASK:        prdata = CSR_DATA_W'(cfg_ff.present_mask);
         REG_SPAWNABLE_MASK:      prdata = CSR_DATA_W'(cfg_ff.spawnable_mask);
         REG_REQUIRE_VALID_CLASS: prdata = CSR_DATA_W'(cfg_ff.require_valid_class);
         default:                 prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/wrcfs_filter.sv]
// ----------------------------------------------------------------------------
// wrcfs_filter
// First stage: eligibility per entry, running weight sums and the product of
// the draw with the total eligible weight, registered for the pick stage.
// ----------------------------------------------------------------------------
module wrcfs_filter #(
   parameter int NUM_ENTRIES = 8,
   parameter int NUM_CLASSES = 8,
   parameter int WEIGHT_BITS = 8,
   localparam int ENT    = (NUM_ENTRIES < wrcfs_pkg::MASK_W) ? NUM_ENTRIES : wrcfs_pkg::MASK_W,
   localparam int SUM_W  = WEIGHT_BITS + 3,
   localparam int PROD_W = wrcfs_pkg::DRAW_W + SUM_W
) (
   input  logic                              clock,
   input  logic                              load,
   input  wrcfs_pkg::cfg_type                cfg,
   input  logic [wrcfs_pkg::CLASS_W-1:0]     player_class,
   input  logic [wrcfs_pkg::DRAW_W-1:0]      random_draw,
   output logic [wrcfs_pkg::MASK_W-1:0]      elig,
   output logic [ENT-1:0][SUM_W-1:0]         run,
   output logic [PROD_W-1:0]                 prod
);
   import wrcfs_pkg::*;

   localparam logic [15:0] CLASS_ALL = 16'((32'd1 << NUM_CLASSES) - 32'd1);

   logic [MASK_W-1:0]                elig_in;
   logic [ENT-1:0][WEIGHT_BITS-1:0]  weight;
   logic [ENT-1:0][SUM_W-1:0]        run_in;
   logic [PROD_W-1:0]                prod_in;
   logic [MASK_W-1:0]                elig_ff;
   logic [ENT-1:0][SUM_W-1:0]        run_ff;
   logic [PROD_W-1:0]                prod_ff;

   for (genvar i = 0; i < ENT; i++) begin : g_ent
      localparam int WSH = i * WEIGHT_BITS;
      localparam int CSH = i * NUM_CLASSES;
      logic [15:0] cmask;
      logic        admit;

      assign weight[i] = WEIGHT_BITS'(cfg.entry_weights >> WSH);
      assign cmask     = 16'(cfg.class_masks >> CSH) & CLASS_ALL;
      if (CSH >= 64) begin : g_out
         assign admit = 1'b0;
      end else begin : g_in
         assign admit = (cmask == CLASS_ALL)
                     || (({2'b00, player_class} < 5'(NUM_CLASSES))
                         && cmask[{1'b0, player_class}]);
      end
      assign elig_in[i] = cfg.present_mask[i] & cfg.spawnable_mask[i] & admit;
   end

   if (ENT < MASK_W) begin : g_pad
      assign elig_in[MASK_W-1:ENT] = '0;
   end

   always_comb begin
      run_in[0] = elig_in[0] ? SUM_W'(weight[0]) : '0;
      for (int i = 1; i < ENT; i++) begin
         run_in[i] = run_in[i-1] + (elig_in[i] ? SUM_W'(weight[i]) : '0);
      end
   end

   assign prod_in = PROD_W'(random_draw) * PROD_W'(run_in[ENT-1]);

   always_ff @(posedge clock) begin
      if (load) begin
         elig_ff <= elig_in;
         run_ff  <= run_in;
         prod_ff <= prod_in;
      end
   end

   assign elig = elig_ff;
   assign run  = run_ff;
   assign prod = prod_ff;

endmodule

[rtl/wrcfs_pick.sv]
// ----------------------------------------------------------------------------
// wrcfs_pick
// Second stage: scales the product down by the full-scale draw, finds the
// first eligible entry whose running sum reaches the point, applies the
// zero-weight and fallback rules and registers the result.
// ----------------------------------------------------------------------------
module wrcfs_pick #(
   parameter int NUM_ENTRIES = 8,
   parameter int WEIGHT_BITS = 8,
   localparam int ENT    = (NUM_ENTRIES < wrcfs_pkg::MASK_W) ? NUM_ENTRIES : wrcfs_pkg::MASK_W,
   localparam int SUM_W  = WEIGHT_BITS + 3,
   localparam int PROD_W = wrcfs_pkg::DRAW_W + SUM_W
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          require_valid_class,
   input  logic                          entry0_present,
   input  logic [wrcfs_pkg::MASK_W-1:0]  elig,
   input  logic [ENT-1:0][SUM_W-1:0]     run,
   input  logic [PROD_W-1:0]             prod,
   output wrcfs_pkg::result_type         result
);
   import wrcfs_pkg::*;

   localparam int R_W = ((SUM_W > 16) ? SUM_W : 16) + 2;

   logic [SUM_W-1:0]   q1;
   logic [R_W-1:0]     r1;
   logic [R_W-17:0]    q2;
   logic [16:0]        r2;
   logic               corr;
   logic [SUM_W-1:0]   point;
   logic [ENT-1:0]     hit;
   logic [INDEX_W-1:0] weighted_idx;
   logic [INDEX_W-1:0] first_idx;
   logic               zero_total;
   result_type         result_in;
   result_type         result_ff;

   // Division by 65535 through two folds of the high half plus one correction.
   assign q1    = prod[PROD_W-1:16];
   assign r1    = R_W'(prod[15:0]) + R_W'(q1);
   assign q2    = r1[R_W-1:16];
   assign r2    = {1'b0, r1[15:0]} + 17'(q2);
   assign corr  = (r2 >= DRAW_MAX);
   assign point = q1 + SUM_W'(q2) + SUM_W'(corr);

   assign zero_total = (run[ENT-1] == '0);

   for (genvar i = 0; i < ENT; i++) begin : g_hit
      assign hit[i] = elig[i] && (point <= run[i]);
   end

   always_comb begin
      weighted_idx = '0;
      first_idx    = '0;
      for (int i = ENT - 1; i >= 0; i--) begin
         if (hit[i]) begin
            weighted_idx = INDEX_W'(i);
         end
         if (elig[i]) begin
            first_idx = INDEX_W'(i);
         end
      end
   end

   always_comb begin
      result_in.eligible_mask = elig;
      result_in.found         = 1'b1;
      result_in.entry_index   = '0;
      result_in.pick_kind     = PICK_WEIGHTED;
      if (elig == '0) begin
         if (!require_valid_class && entry0_present) begin
            result_in.pick_kind = PICK_FALLBACK;
         end else begin
            result_in.found     = 1'b0;
            result_in.pick_kind = PICK_NONE;
         end
      end else if (zero_total) begin
         result_in.entry_index = first_idx;
         result_in.pick_kind   = PICK_ZERO_WEIGHT;
      end else begin
         result_in.entry_index = weighted_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[rtl/weighted_random_class_filtered_select.sv]
// ----------------------------------------------------------------------------
// weighted_random_class_filtered_select
// Path: a result is valid once its request has passed the input, product and result registers.
// Throughput: one transaction per cycle through the input, product and result
// registers; a stalled result backs up only as far as the first empty stage.
// Reset: synchronous, clears all stage valids and loads the register defaults.
// Picks one of the configured entries by class-filtered weighted random draw.
// ----------------------------------------------------------------------------
module weighted_random_class_filtered_select #(
   parameter int NUM_ENTRIES = 8,
   parameter int NUM_CLASSES = 8,
   parameter int WEIGHT_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [wrcfs_pkg::CLASS_W-1:0]    req_player_class,
   input  logic [wrcfs_pkg::DRAW_W-1:0]     req_random_draw,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_found,
   output logic [wrcfs_pkg::INDEX_W-1:0]    rsp_entry_index,
   output logic [1:0]                       rsp_pick_kind,
   output logic [wrcfs_pkg::MASK_W-1:0]     rsp_eligible_mask,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [wrcfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wrcfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wrcfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import wrcfs_pkg::*;

   localparam int ENT    = (NUM_ENTRIES < MASK_W) ? NUM_ENTRIES : MASK_W;
   localparam int SUM_W  = WEIGHT_BITS + 3;
   localparam int PROD_W = DRAW_W + SUM_W;

   cfg_type                   cfg;
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic                      s2_valid_ff;
   logic                      s2_valid_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      s1_load;
   logic                      s2_load;
   logic                      out_load;
   logic [CLASS_W-1:0]        class_ff;
   logic [DRAW_W-1:0]         draw_ff;
   logic [MASK_W-1:0]         s2_elig;
   logic [ENT-1:0][SUM_W-1:0] s2_run;
   logic [PROD_W-1:0]         s2_prod;
   result_type                result;

   wrcfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;

   assign out_load  = s2_valid_ff && (!out_valid_ff || !rsp_stall);
   assign s2_load   = s1_valid_ff && (!s2_valid_ff || out_load);
   assign req_stall = s1_valid_ff && !s2_load;
   assign s1_load   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = s1_load || (s1_valid_ff && !s2_load);
      s2_valid_in  = s2_load || (s2_valid_ff && !out_load);
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         class_ff <= req_player_class;
         draw_ff  <= req_random_draw;
      end
   end

   wrcfs_filter #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .NUM_CLASSES (NUM_CLASSES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_filter (
      .clock        (clock),
      .load         (s2_load),
      .cfg          (cfg),
      .player_class (class_ff),
      .random_draw  (draw_ff),
      .elig         (s2_elig),
      .run          (s2_run),
      .prod         (s2_prod)
   );

   wrcfs_pick #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_pick (
      .clock               (clock),
      .load                (out_load),
      .require_valid_class (cfg.require_valid_class),
      .entry0_present      (cfg.present_mask[0]),
      .elig                (s2_elig),
      .run                 (s2_run),
      .prod                (s2_prod),
      .result              (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = result.found;
   assign rsp_entry_index   = result.entry_index;
   assign rsp_pick_kind     = result.pick_kind;
   assign rsp_eligible_mask = result.eligible_mask;

endmodule

[rtl/wrcfs_checker.sv]
// ----------------------------------------------------------------------------
// wrcfs_checker
// Port-level checks of the selector's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module wrcfs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_found,
   input logic [wrcfs_pkg::INDEX_W-1:0]    rsp_entry_index,
   input logic [1:0]                       rsp_pick_kind,
   input logic [wrcfs_pkg::MASK_W-1:0]     rsp_eligible_mask
);
   import wrcfs_pkg::*;

   // The result channel comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_entry_index) && $stable(rsp_pick_kind)
         && $stable(rsp_eligible_mask))
      else $error("stalled result changed");

   // Found and the pick kind must agree, and a miss reports index zero.
   a_found_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_pick_kind != PICK_NONE))
         && (rsp_found || rsp_entry_index == '0))
      else $error("found flag and pick kind disagree");

   // A weighted or zero-weight pick must name an eligible entry.
   a_pick_eligible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pick_kind == PICK_WEIGHTED || rsp_pick_kind == PICK_ZERO_WEIGHT)
         |-> rsp_eligible_mask[rsp_entry_index])
      else $error("picked entry is not eligible");

   // Fallback and none only happen when nothing is eligible.
   a_fallback_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pick_kind == PICK_FALLBACK || rsp_pick_kind == PICK_NONE)
         |-> rsp_eligible_mask == '0 && rsp_entry_index == '0)
      else $error("fallback with eligible entries");

endmodule

bind weighted_random_class_filtered_select wrcfs_checker u_checker (.*);
